@@ hw/rtl/aft_pkg.sv @@
// ============================================================================
// aft_pkg: shared types and constants of the affine column transform
// Column word, coefficient bundle, stage op codes, register indexes and the
// fixed-point constants of the sine/cosine series.
// ============================================================================
package aft_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ORDER     = 3'd0;
    localparam logic [2:0] CFG_SHIFT_X   = 3'd1;
    localparam logic [2:0] CFG_SHIFT_Y   = 3'd2;
    localparam logic [2:0] CFG_SHIFT_Z   = 3'd3;
    localparam logic [2:0] CFG_ANGLE     = 3'd4;
    localparam logic [2:0] CFG_STRETCH_X = 3'd5;
    localparam logic [2:0] CFG_STRETCH_Y = 3'd6;
    localparam logic [2:0] CFG_STRETCH_Z = 3'd7;

    // application order codes
    localparam logic [2:0] ORD_SRT = 3'd0;
    localparam logic [2:0] ORD_STR = 3'd1;
    localparam logic [2:0] ORD_RST = 3'd2;
    localparam logic [2:0] ORD_RTS = 3'd3;
    localparam logic [2:0] ORD_TSR = 3'd4;
    localparam logic [2:0] ORD_TRS = 3'd5;

    // angle units: 1/64 degree
    localparam logic [14:0] ANG_QUAD  = 15'd5760;
    localparam logic [12:0] ANG_OCT   = 13'd2880;
    localparam logic [32:0] RAD_Q40   = 33'd299845282;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [3:0]  SER_SIN_LAST = 4'd4;
    localparam logic [3:0]  SER_LAST     = 4'd10;
    localparam logic [3:0]  MAT_LAST     = 4'd13;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_SCALE,
        OP_ROT,
        OP_SHIFT
    } t_op;

    typedef struct packed {
        logic             item_valid;
        logic             last;
        logic             sat;
        logic [2:0][31:0] e;
        logic [31:0]      w;
    } t_col;

    typedef struct packed {
        logic [2:0][2:0][31:0] rm;
        logic [2:0][35:0]      stretch;
        logic [2:0][30:0]      shift;
    } t_coef;

    // operation of pipeline slot k for a given order mode
    function automatic t_op slot_op(input logic [2:0] mode, input logic [1:0] k);
        t_op a;
        t_op b;
        t_op c;
        case (mode)
            ORD_STR: begin a = OP_SCALE; b = OP_SHIFT; c = OP_ROT;   end
            ORD_RST: begin a = OP_ROT;   b = OP_SCALE; c = OP_SHIFT; end
            ORD_RTS: begin a = OP_ROT;   b = OP_SHIFT; c = OP_SCALE; end
            ORD_TSR: begin a = OP_SHIFT; b = OP_SCALE; c = OP_ROT;   end
            ORD_TRS: begin a = OP_SHIFT; b = OP_ROT;   c = OP_SCALE; end
            default: begin a = OP_SCALE; b = OP_ROT;   c = OP_SHIFT; end
        endcase
        case (k)
            2'd0:    return a;
            2'd1:    return b;
            default: return c;
        endcase
    endfunction

    // Horner divisors as reciprocals, sine terms first, then cosine terms:
    // 110, 72, 42, 20, 6, then 132, 90, 56, 30, 12, 2.
    // m = ceil(2^k / d) with 2^(k-30) >= d gives an exact floor for n < 2^30.
    function automatic logic [31:0] ser_recip(input logic [3:0] n);
        case (n)
            4'd0:    return 32'd1249445032;
            4'd1:    return 32'd1908874354;
            4'd2:    return 32'd1636178018;
            4'd3:    return 32'd1717986919;
            4'd4:    return 32'd1431655766;
            4'd5:    return 32'd2082408386;
            4'd6:    return 32'd1527099484;
            4'd7:    return 32'd1227133514;
            4'd8:    return 32'd1145324613;
            4'd9:    return 32'd1431655766;
            default: return 32'd1073741824;
        endcase
    endfunction

    function automatic logic [5:0] ser_shift(input logic [3:0] n);
        case (n)
            4'd0:    return 6'd37;
            4'd1:    return 6'd37;
            4'd2:    return 6'd36;
            4'd3:    return 6'd35;
            4'd4:    return 6'd33;
            4'd5:    return 6'd38;
            4'd6:    return 6'd37;
            4'd7:    return 6'd36;
            4'd8:    return 6'd35;
            4'd9:    return 6'd34;
            default: return 6'd31;
        endcase
    endfunction

endpackage

@@ hw/rtl/aft_slot.sv @@
// ============================================================================
// aft_slot: one transform step of the column pipeline
// Multiply register (nine 32x32 products), then round, sum and saturate.
// Performs scale, rotate or translate as selected; pass for invalid columns.
// ============================================================================
module aft_slot #(
    parameter int STAGE_W = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aft_pkg::t_op  i_op,
    input  aft_pkg::t_coef i_coef,
    input  logic          i_valid,
    input  aft_pkg::t_col i_col,
    output logic          o_ready,
    output logic          o_valid,
    output aft_pkg::t_col o_col,
    input  logic          i_ready
);
    import aft_pkg::*;

    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (STAGE_W - 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;
    localparam logic signed [65:0] HALF30 = 66'sd536870912;
    localparam logic signed [65:0] HALF16 = 66'sd32768;
    localparam logic signed [65:0] HALF10 = 66'sd512;

    logic               a_ready;
    logic               b_ready;
    t_op                op_eff;
    logic signed [31:0] ma    [3][3];
    logic signed [31:0] mb    [3][3];
    logic signed [63:0] mprod [3][3];

    logic               r_a_vld;
    t_op                r_a_op;
    t_col               r_a_col;
    logic signed [63:0] r_prod [3][3];

    logic               r_b_vld;
    t_col               r_b_col;
    t_col               n_b_col;

    assign b_ready = !r_b_vld || i_ready;
    assign a_ready = !r_a_vld || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_vld;
    assign o_col   = r_b_col;

    always_comb begin
        op_eff = i_col.item_valid ? i_op : OP_PASS;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ma[i][j] = '0;
                mb[i][j] = '0;
                case (op_eff)
                    OP_ROT: begin
                        ma[i][j] = $signed(i_coef.rm[i][j]);
                        mb[i][j] = $signed(i_col.e[j]);
                    end
                    OP_SCALE: begin
                        mb[i][j] = $signed(i_col.e[i]);
                        if (j == 0) begin
                            ma[i][j] = $signed({12'd0, i_coef.stretch[i][35:16]});
                        end else if (j == 1) begin
                            ma[i][j] = $signed({16'd0, i_coef.stretch[i][15:0]});
                        end
                    end
                    OP_SHIFT: begin
                        if (j == 0) begin
                            ma[i][j] = $signed({i_coef.shift[i][30], i_coef.shift[i]});
                            mb[i][j] = $signed(i_col.w);
                        end
                    end
                    default: ;
                endcase
                mprod[i][j] = ma[i][j] * mb[i][j];
            end
        end
    end

    // round half up, sum, clip to the stage width
    always_comb begin
        logic signed [65:0] p0;
        logic signed [65:0] p1;
        logic signed [65:0] p2;
        logic signed [65:0] ev;
        logic signed [65:0] v;
        n_b_col = r_a_col;
        for (int i = 0; i < 3; i++) begin
            p0 = {{2{r_prod[i][0][63]}}, r_prod[i][0]};
            p1 = {{2{r_prod[i][1][63]}}, r_prod[i][1]};
            p2 = {{2{r_prod[i][2][63]}}, r_prod[i][2]};
            ev = {{34{r_a_col.e[i][31]}}, r_a_col.e[i]};
            case (r_a_op)
                OP_ROT:   v = (p0 + p1 + p2 + HALF30) >>> 30;
                OP_SCALE: v = p0 + ((p1 + HALF16) >>> 16);
                OP_SHIFT: v = ev + ((p0 + HALF10) >>> 10);
                default:  v = ev;
            endcase
            if (r_a_op != OP_PASS && v > SAT_HI) begin
                n_b_col.e[i] = SAT_HI[31:0];
                n_b_col.sat  = 1'b1;
            end else if (r_a_op != OP_PASS && v < SAT_LO) begin
                n_b_col.e[i] = SAT_LO[31:0];
                n_b_col.sat  = 1'b1;
            end else begin
                n_b_col.e[i] = v[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_vld <= i_valid;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_op  <= op_eff;
            r_a_col <= i_col;
            r_prod  <= mprod;
        end
        if (b_ready && r_a_vld) begin
            r_b_col <= n_b_col;
        end
    end

endmodule

@@ hw/rtl/aft_rot.sv @@
// ============================================================================
// aft_rot: rotation matrix builder
// Sequencer over one shared 33x33 multiplier; series divisions are done as
// reciprocal multiplies. Sine/cosine for pitch, yaw and roll, then the nine
// matrix entries.
// ============================================================================
module aft_rot (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [47:0]           i_angle,
    output logic                  o_busy,
    output logic [2:0][2:0][31:0] o_rm
);
    import aft_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RED  = 4'b0010,
        S_MUL  = 4'b0100,
        S_USE  = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        B_RAD,
        B_SQ,
        B_SER,
        B_DIV,
        B_PS,
        B_MAT
    } t_bop;

    t_state r_state;
    t_bop   r_bop;
    logic [1:0] r_axis;
    logic [3:0] r_n;
    logic [3:0] r_mstep;

    logic [11:0]        r_g;
    logic [1:0]         r_q;
    logic               r_swap;
    logic [30:0]        r_x;
    logic [30:0]        r_x2;
    logic [30:0]        r_acc;
    logic [30:0]        r_ts;
    logic signed [65:0] r_prod;
    logic [30:0]        r_dq;
    logic signed [31:0] r_sin [3];
    logic signed [31:0] r_cos [3];
    logic signed [31:0] r_sysx;
    logic signed [31:0] r_cysx;
    logic signed [31:0] r_mac;
    logic [2:0][2:0][31:0] r_rm;

    logic [15:0]        ang16;
    logic signed [17:0] a18;
    logic signed [17:0] red;
    logic [14:0]        red_u;
    logic [1:0]         quad;
    logic [12:0]        f;
    logic               swap;
    logic [11:0]        g;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] mprod;
    logic [65:0]        rad_sum;
    logic [30:0]        shr30;
    logic signed [65:0] rnd_sum;
    logic signed [32:0] mat_v;
    logic signed [32:0] mac33;
    logic [30:0]        quo;
    logic [30:0]        ser_acc;
    logic signed [31:0] s0;
    logic signed [31:0] c0;
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
    logic signed [31:0] sx;
    logic signed [31:0] cx;
    logic signed [31:0] sy;
    logic signed [31:0] cy;
    logic signed [31:0] sz;
    logic signed [31:0] cz;

    function automatic logic [31:0] clamp30(input logic signed [32:0] v);
        if (v > 33'sd1073741824) begin
            return 32'h4000_0000;
        end else if (v < -33'sd1073741824) begin
            return 32'hC000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    assign o_busy = (r_state != S_IDLE);
    assign o_rm   = r_rm;

    assign sx = r_sin[0];
    assign cx = r_cos[0];
    assign sy = r_sin[1];
    assign cy = r_cos[1];
    assign sz = r_sin[2];
    assign cz = r_cos[2];

    // angle reduction to quadrant and folded offset
    always_comb begin
        case (r_axis)
            2'd0:    ang16 = i_angle[15:0];
            2'd1:    ang16 = i_angle[31:16];
            default: ang16 = i_angle[47:32];
        endcase
        a18 = {{2{ang16[15]}}, ang16};
        if (a18 >= 18'sd23040) begin
            red = a18 - 18'sd23040;
        end else if (a18 >= 18'sd0) begin
            red = a18;
        end else if (a18 >= -18'sd23040) begin
            red = a18 + 18'sd23040;
        end else begin
            red = a18 + 18'sd46080;
        end
        red_u = red[14:0];
        if (red_u < ANG_QUAD) begin
            quad = 2'd0;
            f    = red_u[12:0];
        end else if (red_u < 15'(2 * ANG_QUAD)) begin
            quad = 2'd1;
            f    = 13'(red_u - ANG_QUAD);
        end else if (red_u < 15'(3 * ANG_QUAD)) begin
            quad = 2'd2;
            f    = 13'(red_u - 15'(2 * ANG_QUAD));
        end else begin
            quad = 2'd3;
            f    = 13'(red_u - 15'(3 * ANG_QUAD));
        end
        swap = (f > ANG_OCT);
        g    = swap ? 12'(ANG_QUAD[12:0] - f) : f[11:0];
    end

    // shared multiplier operands
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_bop)
            B_RAD: begin ma = {21'd0, r_g}; mb = RAD_Q40; end
            B_SQ:  begin ma = {2'd0, r_x};  mb = {2'd0, r_x}; end
            B_SER: begin ma = {2'd0, r_x2}; mb = {2'd0, r_acc}; end
            B_DIV: begin ma = {2'd0, r_dq}; mb = {1'b0, ser_recip(r_n)}; end
            B_PS:  begin ma = {2'd0, r_x};  mb = {2'd0, r_ts}; end
            B_MAT: begin
                case (r_mstep)
                    4'd0:    begin ma = 33'(sy);     mb = 33'(sx); end
                    4'd1:    begin ma = 33'(cy);     mb = 33'(sx); end
                    4'd2:    begin ma = 33'(cy);     mb = 33'(cz); end
                    4'd3:    begin ma = 33'(r_sysx); mb = 33'(sz); end
                    4'd4:    begin ma = 33'(r_sysx); mb = 33'(cz); end
                    4'd5:    begin ma = 33'(cy);     mb = 33'(sz); end
                    4'd6:    begin ma = 33'(sy);     mb = 33'(cx); end
                    4'd7:    begin ma = 33'(cx);     mb = 33'(sz); end
                    4'd8:    begin ma = 33'(cx);     mb = 33'(cz); end
                    4'd9:    begin ma = 33'(r_cysx); mb = 33'(sz); end
                    4'd10:   begin ma = 33'(sy);     mb = 33'(cz); end
                    4'd11:   begin ma = 33'(sy);     mb = 33'(sz); end
                    4'd12:   begin ma = 33'(r_cysx); mb = 33'(cz); end
                    default: begin ma = 33'(cy);     mb = 33'(cx); end
                endcase
            end
            default: ;
        endcase
        mprod = ma * mb;
    end

    // product post-processing, series quotient, quadrant mapping
    always_comb begin
        rad_sum = r_prod + 66'sd512;
        shr30   = r_prod[60:30];
        rnd_sum = r_prod + 66'sd536870912;
        mat_v   = rnd_sum[62:30];
        mac33   = {r_mac[31], r_mac};

        quo     = 31'(r_prod[61:0] >> ser_shift(r_n));
        ser_acc = Q30_ONE - quo;

        // r_acc holds the cosine series here
        s0 = r_swap ? $signed({1'b0, r_acc}) : $signed({1'b0, shr30});
        c0 = r_swap ? $signed({1'b0, shr30}) : $signed({1'b0, r_acc});
        case (r_q)
            2'd1:    begin sin_v = c0;  cos_v = -s0; end
            2'd2:    begin sin_v = -s0; cos_v = -c0; end
            2'd3:    begin sin_v = -c0; cos_v = s0;  end
            default: begin sin_v = s0;  cos_v = c0;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RED;
            r_axis  <= '0;
            r_bop   <= B_RAD;
            r_n     <= '0;
            r_mstep <= '0;
        end else if (i_start) begin
            r_state <= S_RED;
            r_axis  <= '0;
        end else begin
            case (r_state)
                S_IDLE: ;
                S_RED: begin
                    r_g     <= g;
                    r_q     <= quad;
                    r_swap  <= swap;
                    r_bop   <= B_RAD;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mprod;
                    r_state <= S_USE;
                end
                S_USE: begin
                    case (r_bop)
                        B_RAD: begin
                            r_x     <= rad_sum[40:10];
                            r_bop   <= B_SQ;
                            r_state <= S_MUL;
                        end
                        B_SQ: begin
                            r_x2    <= shr30;
                            r_acc   <= Q30_ONE;
                            r_n     <= '0;
                            r_bop   <= B_SER;
                            r_state <= S_MUL;
                        end
                        B_SER: begin
                            r_dq    <= shr30;
                            r_bop   <= B_DIV;
                            r_state <= S_MUL;
                        end
                        B_DIV: begin
                            r_state <= S_MUL;
                            if (r_n == SER_SIN_LAST) begin
                                r_ts  <= ser_acc;
                                r_acc <= Q30_ONE;
                                r_n   <= r_n + 4'd1;
                                r_bop <= B_SER;
                            end else if (r_n == SER_LAST) begin
                                r_acc <= ser_acc;
                                r_bop <= B_PS;
                            end else begin
                                r_acc <= ser_acc;
                                r_n   <= r_n + 4'd1;
                                r_bop <= B_SER;
                            end
                        end
                        B_PS: begin
                            r_sin[r_axis] <= sin_v;
                            r_cos[r_axis] <= cos_v;
                            if (r_axis == 2'd2) begin
                                r_bop   <= B_MAT;
                                r_mstep <= '0;
                                r_state <= S_MUL;
                            end else begin
                                r_axis  <= r_axis + 2'd1;
                                r_state <= S_RED;
                            end
                        end
                        B_MAT: begin
                            case (r_mstep)
                                4'd0:    r_sysx <= mat_v[31:0];
                                4'd1:    r_cysx <= mat_v[31:0];
                                4'd3:    r_rm[0][0] <= clamp30(mac33 + mat_v);
                                4'd5:    r_rm[0][1] <= clamp30(mac33 - mat_v);
                                4'd6:    r_rm[0][2] <= clamp30(mat_v);
                                4'd7:    r_rm[1][0] <= clamp30(mat_v);
                                4'd8:    r_rm[1][1] <= clamp30(mat_v);
                                4'd10:   r_rm[2][0] <= clamp30(mac33 - mat_v);
                                4'd12:   r_rm[2][1] <= clamp30(mac33 + mat_v);
                                4'd13: begin
                                    r_rm[2][2] <= clamp30(mat_v);
                                    r_rm[1][2] <= clamp30(-33'(sx));
                                end
                                default: r_mac <= mat_v[31:0];
                            endcase
                            if (r_mstep == MAT_LAST) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_mstep <= r_mstep + 4'd1;
                                r_state <= S_MUL;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/affine_transform_ordered.sv @@
// ============================================================================
// affine_transform_ordered: streaming 4x4 affine transform, one column a word
// Scale, rotate and translate applied to each column in a selectable order,
// every step rounded and saturated; columns without item_valid pass as is.
// ============================================================================
//
//  channel   signals                                   direction
//  -------   ----------------------------------------  ---------
//  column    i_valid / o_stall, i_item_valid..i_col_last  in
//  result    o_valid / i_stall, o_out_x..o_out_saturated  out
//  config    i_cfg_valid / o_cfg_ready, index, data       in
//
//  One column per cycle while o_stall is low (three slots, two registers each).
//  After reset and after every angle write the rotation builder runs
//  (one shared multiplier, series divisions done as reciprocal multiplies);
//  o_stall stays high meanwhile. Config writes are always taken.
//  An output stall backs up stage by stage; empty stages keep filling.
//
module affine_transform_ordered #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_item_valid,
    input  logic [31:0] i_col_x,
    input  logic [31:0] i_col_y,
    input  logic [31:0] i_col_z,
    input  logic [31:0] i_col_w,
    input  logic        i_col_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [31:0] o_out_w,
    output logic        o_out_last,
    output logic        o_out_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import aft_pkg::*;

    localparam int STAGE_W = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;

    logic [2:0]       r_order;
    logic [2:0][30:0] r_shift;
    logic [47:0]      r_angle;
    logic [2:0][35:0] r_stretch;

    logic                  cfg_we;
    logic                  rot_start;
    logic                  busy;
    logic [2:0][2:0][31:0] rm;
    t_coef                 coef;
    t_col                  col   [4];
    logic                  vld   [4];
    logic                  rdy   [4];

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign rot_start   = cfg_we && (i_cfg_index == CFG_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order   <= ORD_SRT;
            r_shift   <= '0;
            r_angle   <= '0;
            r_stretch <= {3{36'd65536}};
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_ORDER:     r_order      <= i_cfg_data[2:0];
                CFG_SHIFT_X:   r_shift[0]   <= i_cfg_data[30:0];
                CFG_SHIFT_Y:   r_shift[1]   <= i_cfg_data[30:0];
                CFG_SHIFT_Z:   r_shift[2]   <= i_cfg_data[30:0];
                CFG_ANGLE:     r_angle      <= i_cfg_data;
                CFG_STRETCH_X: r_stretch[0] <= i_cfg_data[35:0];
                CFG_STRETCH_Y: r_stretch[1] <= i_cfg_data[35:0];
                default:       r_stretch[2] <= i_cfg_data[35:0];
            endcase
        end
    end

    // builder reads the stored angles again for each axis while it runs
    aft_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_angle (r_angle),
        .o_busy  (busy),
        .o_rm    (rm)
    );

    assign coef.rm      = rm;
    assign coef.stretch = r_stretch;
    assign coef.shift   = r_shift;

    assign col[0].item_valid = i_item_valid;
    assign col[0].last       = i_col_last;
    assign col[0].sat        = 1'b0;
    assign col[0].e[0]       = i_col_x;
    assign col[0].e[1]       = i_col_y;
    assign col[0].e[2]       = i_col_z;
    assign col[0].w          = i_col_w;
    assign vld[0]            = i_valid && !busy;
    assign o_stall           = busy || !rdy[0];

    for (genvar k = 0; k < 3; k++) begin : g_slot
        aft_slot #(
            .STAGE_W (STAGE_W)
        ) u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (slot_op(r_order, 2'(k))),
            .i_coef  (coef),
            .i_valid (vld[k]),
            .i_col   (col[k]),
            .o_ready (rdy[k]),
            .o_valid (vld[k+1]),
            .o_col   (col[k+1]),
            .i_ready (rdy[k+1])
        );
    end

    assign rdy[3]          = !i_stall;
    assign o_valid         = vld[3];
    assign o_out_x         = col[3].e[0];
    assign o_out_y         = col[3].e[1];
    assign o_out_z         = col[3].e[2];
    assign o_out_w         = col[3].w;
    assign o_out_last      = col[3].last;
    assign o_out_saturated = col[3].sat;

    // the builder holds off columns while the angles are being turned into R
    a_angle_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rot_start |=> o_stall)
        else $error("angle write did not stall the column input");

    a_reset_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_stall)
        else $error("column input open before rotation built after reset");

    a_rot_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> ($signed(rm[0][0]) <= 32'sd1073741824 &&
                   $signed(rm[0][0]) >= -32'sd1073741824 &&
                   $signed(rm[2][1]) <= 32'sd1073741824 &&
                   $signed(rm[2][1]) >= -32'sd1073741824))
        else $error("rotation entry beyond unit range");

endmodule
